>>> design/spcf_pkg.sv
// Package: shared payload types and fixed widths for the sphere pair collision force unit.
`timescale 1ns / 1ps

package spcf_pkg;

    localparam int COORD_W  = 32;
    localparam int RAD_W    = 31;
    localparam int DIFF_W   = 33;
    localparam int SQR_W    = 65;
    localparam int SUM_W    = 66;
    localparam int ROOT_W   = 33;
    localparam int REM_W    = 35;
    localparam int SQ_STEPS = 33;
    localparam int AXES     = 3;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_a_x;
        logic signed [COORD_W-1:0] center_a_y;
        logic signed [COORD_W-1:0] center_a_z;
        logic        [RAD_W-1:0]   radius_a;
        logic signed [COORD_W-1:0] center_b_x;
        logic signed [COORD_W-1:0] center_b_y;
        logic signed [COORD_W-1:0] center_b_z;
        logic        [RAD_W-1:0]   radius_b;
    } spcf_in_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] force_x;
        logic signed [COORD_W-1:0] force_y;
        logic signed [COORD_W-1:0] force_z;
    } spcf_out_t;

    // Centre offset magnitudes, signs and radius sum, carried alongside the root
    typedef struct packed {
        logic [AXES-1:0]              neg;
        logic [AXES-1:0][DIFF_W-1:0] mag;
        logic [COORD_W-1:0]          rsum;
    } spcf_geom_t;

endpackage

>>> design/sphere_pair_collision_force_unit.sv
// Top level: sphere pair collision test and penalty force, fully pipelined.
//
// Channels: in (in_valid/in_ready/in_data) takes one sphere pair per request,
// out (out_valid/out_ready/out_data) returns hit and the force on sphere B
// for every request, in order. cfg (cfg_valid/cfg_ready/cfg_data) writes
// force_gain, unsigned with FRAC_BITS fraction bits; write it only when idle.
// Throughput: one request per cycle while the receiver keeps out_ready high.
// Pipeline: the 3-stage front end, the 33-stage square root, the FRAC_BITS+1-stage
// divider and four single stages around them.
// Stall: the whole pipeline freezes while out_valid is high and out_ready is
// low; in_ready drops with it, so nothing is lost or duplicated.
// Reset: all valid bits clear, force_gain returns to 0.5.
// Forces are zero on a miss and when the centres coincide.
`timescale 1ns / 1ps

module sphere_pair_collision_force_unit
    import spcf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  spcf_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output spcf_out_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int M_W    = 64 - FRAC_BITS;        // width of scaled overlap
    localparam int PROD_W = FRAC_BITS + 1 + M_W;   // quotient times magnitude
    localparam int P_W    = PROD_W - FRAC_BITS;
    localparam int SB_W   = 2 + AXES + M_W;
    localparam logic [31:0] GAIN_RESET = 32'd1 << (FRAC_BITS - 1);

    logic adv;
    logic [31:0] gain_reg;

    // front end and root
    logic              fe_v;
    logic [SUM_W-1:0]  fe_s;
    spcf_geom_t        fe_geom;
    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    spcf_geom_t        sq_geom;

    // compare stage
    logic               a_v_reg;
    logic               a_hit_reg, a_en_reg;
    logic [31:0]        a_ovl_reg;
    logic [ROOT_W-1:0]  a_dist_reg;
    spcf_geom_t         a_geom_reg;
    logic               a_hit_next;
    logic [31:0]        a_ovl_next;

    // gain stage
    logic               b_v_reg;
    logic               b_hit_reg, b_en_reg;
    logic [M_W-1:0]     b_m_reg;
    logic [ROOT_W-1:0]  b_dist_reg;
    spcf_geom_t         b_geom_reg;
    logic [63:0]        b_prod_next;

    // divider
    logic                         dv_v;
    logic [AXES-1:0][FRAC_BITS:0] dv_q;
    logic [SB_W-1:0]              dv_sb;
    logic                         dv_hit, dv_en;
    logic [AXES-1:0]              dv_neg;
    logic [M_W-1:0]               dv_m;

    // product and output stages
    logic                         c_v_reg, c_hit_reg, c_en_reg;
    logic [AXES-1:0]              c_neg_reg;
    logic [AXES-1:0][PROD_W-1:0]  c_prod_reg;
    logic                         d_v_reg;
    spcf_out_t                    d_out_reg;
    logic [AXES-1:0][31:0]        d_force_next;

    // pipeline moves whenever the output register is free or being drained
    assign adv       = !d_v_reg || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid)
        begin
            gain_reg <= cfg_data;
        end
    end

    spcf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_v     (in_valid),
        .in_d     (in_data),
        .out_v    (fe_v),
        .out_s    (fe_s),
        .out_geom (fe_geom)
    );

    spcf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_v     (fe_v),
        .in_s     (fe_s),
        .in_geom  (fe_geom),
        .out_v    (sq_v),
        .out_root (sq_root),
        .out_geom (sq_geom)
    );

    // hit when floor(sqrt) is below the radius sum; overlap is then below 2^32
    assign a_hit_next = sq_root < {1'b0, sq_geom.rsum};
    assign a_ovl_next = sq_geom.rsum - sq_root[31:0];

    assign b_prod_next = {32'd0, a_ovl_reg} * {32'd0, gain_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_v_reg <= sq_v;
            b_v_reg <= a_v_reg;
            c_v_reg <= dv_v;
            d_v_reg <= c_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_hit_reg  <= a_hit_next;
            a_en_reg   <= a_hit_next && (sq_root != '0);
            a_ovl_reg  <= a_ovl_next;
            a_dist_reg <= sq_root;
            a_geom_reg <= sq_geom;

            b_hit_reg  <= a_hit_reg;
            b_en_reg   <= a_en_reg;
            b_m_reg    <= b_prod_next[63:FRAC_BITS];
            b_dist_reg <= a_dist_reg;
            b_geom_reg <= a_geom_reg;
        end
    end

    spcf_div #(
        .FRAC_BITS (FRAC_BITS),
        .SB_W      (SB_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_v    (b_v_reg),
        .divisor (b_dist_reg),
        .num     (b_geom_reg.mag),
        .in_sb   ({b_hit_reg, b_en_reg, b_geom_reg.neg, b_m_reg}),
        .out_v   (dv_v),
        .quo     (dv_q),
        .out_sb  (dv_sb)
    );

    assign {dv_hit, dv_en, dv_neg, dv_m} = dv_sb;

    // unit component times magnitude; shift, clamp and sign in the last stage
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            logic [P_W-1:0] p;
            logic [31:0]    mag;
            p = c_prod_reg[i][PROD_W-1:FRAC_BITS];
            mag = '0;
            if (c_neg_reg[i])
            begin
                if ((|p[P_W-1:32]) || (p[31] && (|p[30:0])))
                begin
                    mag = 32'h8000_0000;
                end
                else
                begin
                    mag = p[31:0];
                end
                d_force_next[i] = ~mag + 1'b1;
            end
            else
            begin
                d_force_next[i] = (|p[P_W-1:31]) ? 32'h7FFF_FFFF : p[31:0];
            end
            if (!c_en_reg)
            begin
                d_force_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_hit_reg <= dv_hit;
            c_en_reg  <= dv_en;
            c_neg_reg <= dv_neg;
            for (int i = 0; i < AXES; i++)
            begin
                c_prod_reg[i] <= PROD_W'({{(PROD_W-FRAC_BITS-1){1'b0}}, dv_q[i]} *
                                         {{(FRAC_BITS+1){1'b0}}, dv_m});
            end
            d_out_reg.hit     <= c_hit_reg;
            d_out_reg.force_x <= d_force_next[0];
            d_out_reg.force_y <= d_force_next[1];
            d_out_reg.force_z <= d_force_next[2];
        end
    end

    assign out_valid = d_v_reg;
    assign out_data  = d_out_reg;

endmodule

>>> design/spcf_front.sv
// Front end: centre offsets, squares and the squared distance over three stages.
`timescale 1ns / 1ps

module spcf_front
    import spcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       adv,
    input  logic       in_v,
    input  spcf_in_t   in_d,
    output logic       out_v,
    output logic [SUM_W-1:0] out_s,
    output spcf_geom_t out_geom
);

    logic [AXES-1:0][COORD_W-1:0] ca, cb;
    logic [AXES-1:0][DIFF_W-1:0]  diff;
    spcf_geom_t geom1_next;

    logic       v1_reg, v2_reg, v3_reg;
    spcf_geom_t geom1_reg, geom2_reg, geom3_reg;
    logic [AXES-1:0][SQR_W-1:0] sq2_reg;
    logic [SUM_W-1:0] s3_reg;

    // axis 0 is x, axis 2 is z
    assign ca = {in_d.center_a_z, in_d.center_a_y, in_d.center_a_x};
    assign cb = {in_d.center_b_z, in_d.center_b_y, in_d.center_b_x};

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            diff[i] = {cb[i][COORD_W-1], cb[i]} - {ca[i][COORD_W-1], ca[i]};
            geom1_next.neg[i] = diff[i][DIFF_W-1];
            geom1_next.mag[i] = diff[i][DIFF_W-1] ? (~diff[i] + 1'b1) : diff[i];
        end
        geom1_next.rsum = {1'b0, in_d.radius_a} + {1'b0, in_d.radius_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            geom1_reg <= geom1_next;
            geom2_reg <= geom1_reg;
            geom3_reg <= geom2_reg;
            for (int i = 0; i < AXES; i++)
            begin
                sq2_reg[i] <= SQR_W'({32'd0, geom1_reg.mag[i]} * {32'd0, geom1_reg.mag[i]});
            end
            s3_reg <= {1'b0, sq2_reg[0]} + {1'b0, sq2_reg[1]} + {1'b0, sq2_reg[2]};
        end
    end

    assign out_v    = v3_reg;
    assign out_s    = s3_reg;
    assign out_geom = geom3_reg;

endmodule

>>> design/spcf_sqrt.sv
// Pipelined integer square root, one result digit per stage.
`timescale 1ns / 1ps

module spcf_sqrt
    import spcf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_v,
    input  logic [SUM_W-1:0]  in_s,
    input  spcf_geom_t        in_geom,
    output logic              out_v,
    output logic [ROOT_W-1:0] out_root,
    output spcf_geom_t        out_geom
);

    logic [SQ_STEPS-1:0] v_reg;
    logic [SUM_W-1:0]    s_reg    [SQ_STEPS];
    logic [ROOT_W-1:0]   root_reg [SQ_STEPS];
    logic [REM_W-1:0]    rem_reg  [SQ_STEPS];
    spcf_geom_t          geom_reg [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        localparam int DIG = SQ_STEPS - 1 - k;
        logic              v_in;
        logic [SUM_W-1:0]  s_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W-1:0]  rem_in;
        spcf_geom_t        geom_in;
        logic [REM_W-1:0]  rem_sh, trial;
        logic              take;
        logic [ROOT_W-1:0] root_next;
        logic [REM_W-1:0]  rem_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_v;
            assign s_in    = in_s;
            assign root_in = '0;
            assign rem_in  = '0;
            assign geom_in = in_geom;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[k-1];
            assign s_in    = s_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign geom_in = geom_reg[k-1];
        end

        always_comb
        begin
            rem_sh    = {rem_in[REM_W-3:0], s_in[2*DIG+1 -: 2]};
            trial     = {root_in[REM_W-3:0], 2'b01};
            take      = rem_sh >= trial;
            rem_next  = take ? (rem_sh - trial) : rem_sh;
            root_next = {root_in[ROOT_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s_reg[k]    <= s_in;
                root_reg[k] <= root_next;
                rem_reg[k]  <= rem_next;
                geom_reg[k] <= geom_in;
            end
        end
    end

    assign out_v    = v_reg[SQ_STEPS-1];
    assign out_root = root_reg[SQ_STEPS-1];
    assign out_geom = geom_reg[SQ_STEPS-1];

endmodule

>>> design/spcf_div.sv
// Pipelined restoring divider for the three direction components, one quotient bit per stage.
`timescale 1ns / 1ps

module spcf_div
    import spcf_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SB_W      = 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_v,
    input  logic [ROOT_W-1:0]             divisor,
    input  logic [AXES-1:0][DIFF_W-1:0]   num,
    input  logic [SB_W-1:0]               in_sb,
    output logic                          out_v,
    output logic [AXES-1:0][FRAC_BITS:0]  quo,
    output logic [SB_W-1:0]               out_sb
);

    localparam int STEPS = FRAC_BITS + 1;
    localparam int QW    = FRAC_BITS + 1;
    localparam int RW    = DIFF_W + 1;

    logic [STEPS-1:0]             v_reg;
    logic [ROOT_W-1:0]            divisor_reg [STEPS];
    logic [AXES-1:0][RW-1:0]      rem_reg  [STEPS];
    logic [AXES-1:0][QW-1:0]      q_reg    [STEPS];
    logic [SB_W-1:0]              sb_reg   [STEPS];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic                     v_in;
        logic [ROOT_W-1:0]        divisor_in;
        logic [AXES-1:0][RW-1:0]  rem_in;
        logic [AXES-1:0][QW-1:0]  q_in;
        logic [SB_W-1:0]          sb_in;
        logic [AXES-1:0][RW-1:0]  rem_next;
        logic [AXES-1:0][QW-1:0]  q_next;

        if (k == 0)
        begin : g_first
            assign v_in       = in_v;
            assign divisor_in = divisor;
            assign q_in       = '0;
            assign sb_in      = in_sb;
            for (genvar a = 0; a < AXES; a++)
            begin : g_ax
                assign rem_in[a] = {1'b0, num[a]};
            end
        end
        else
        begin : g_rest
            assign v_in       = v_reg[k-1];
            assign divisor_in = divisor_reg[k-1];
            assign rem_in     = rem_reg[k-1];
            assign q_in       = q_reg[k-1];
            assign sb_in      = sb_reg[k-1];
        end

        always_comb
        begin
            for (int a = 0; a < AXES; a++)
            begin
                logic [RW-1:0] diff;
                logic          ge;
                diff = rem_in[a] - {1'b0, divisor_in};
                ge   = rem_in[a] >= {1'b0, divisor_in};
                // remainder stays below the divisor, so the doubled value fits
                rem_next[a] = {(ge ? diff[RW-2:0] : rem_in[a][RW-2:0]), 1'b0};
                q_next[a]   = {q_in[a][QW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                divisor_reg[k] <= divisor_in;
                rem_reg[k]     <= rem_next;
                q_reg[k]       <= q_next;
                sb_reg[k]      <= sb_in;
            end
        end
    end

    assign out_v  = v_reg[STEPS-1];
    assign quo    = q_reg[STEPS-1];
    assign out_sb = sb_reg[STEPS-1];

endmodule

>>> tb/sv/tb_sphere_pair_collision_force_unit.sv
// Testbench: sphere pair collision force unit, directed table and random pairs.
`timescale 1ns / 1ps

module tb_sphere_pair_collision_force_unit;
    import spcf_pkg::*;

    localparam int FRAC      = 16;
    localparam int LATENCY   = FRAC + 41;
    localparam int N_RANDOM  = 1030;
    localparam int N_ROWS    = 10;
    localparam longint LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    spcf_in_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    spcf_out_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    sphere_pair_collision_force_unit #(.FRAC_BITS(FRAC)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    spcf_out_t   force_queue[$];
    logic [31:0] gain_now;
    int          mismatches = 0;
    int          results_seen = 0;
    int          hits_seen = 0;
    longint      cycles = 0;

    // One directed row; has_want marks rows whose answer is typed in
    typedef struct {
        spcf_in_t  pair;
        bit        has_want;
        spcf_out_t want;
    } pair_row_t;

    function automatic logic [32:0] root66(input logic [65:0] s);
        logic [32:0] r;
        logic [34:0] rem;
        logic [34:0] trial;
        r = '0;
        rem = '0;
        for (int i = 32; i >= 0; i--)
        begin
            rem = {rem[32:0], s[2*i+1 -: 2]};
            trial = {r, 2'b01};
            if (rem >= trial)
            begin
                rem = rem - trial;
                r = {r[31:0], 1'b1};
            end
            else
                r = {r[31:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic signed [31:0] axis_push(input logic signed [32:0] d,
            input logic [32:0] cdist, input logic [63:0] m);
        logic [32:0]  mag;
        logic [63:0]  u;
        logic [127:0] p;
        mag = d[32] ? -d : d;
        u = ({31'b0, mag} << FRAC) / {31'b0, cdist};
        p = u * (m >> FRAC) + ((u * (m & ((64'd1 << FRAC) - 1))) >> FRAC);
        if (d[32])
        begin
            if (p > 128'h8000_0000)
                p = 128'h8000_0000;
            return -p[31:0];
        end
        if (p > 128'h7FFF_FFFF)
            p = 128'h7FFF_FFFF;
        return p[31:0];
    endfunction

    function automatic spcf_out_t predict_force(input spcf_in_t p, input logic [31:0] gain);
        spcf_out_t r;
        logic signed [32:0] dx, dy, dz;
        logic [65:0] s;
        logic [32:0] cdist;
        logic [32:0] rsum;
        logic [63:0] m;
        dx = $signed(p.center_b_x) - $signed(p.center_a_x);
        dy = $signed(p.center_b_y) - $signed(p.center_a_y);
        dz = $signed(p.center_b_z) - $signed(p.center_a_z);
        s = 66'(dx * dx) + 66'(dy * dy) + 66'(dz * dz);
        cdist = root66(s);
        rsum = 33'(p.radius_a) + 33'(p.radius_b);
        r = '0;
        r.hit = cdist < rsum;
        if (r.hit && cdist != 0)
        begin
            m = (64'(rsum - cdist) * 64'(gain)) >> FRAC;
            r.force_x = axis_push(dx, cdist, m);
            r.force_y = axis_push(dy, cdist, m);
            r.force_z = axis_push(dz, cdist, m);
        end
        return r;
    endfunction

    function automatic spcf_in_t make_pair(input int cax, cay, caz, ra,
            input int cbx, cby, cbz, rb);
        spcf_in_t p;
        p.center_a_x = cax; p.center_a_y = cay; p.center_a_z = caz;
        p.radius_a = ra[30:0];
        p.center_b_x = cbx; p.center_b_y = cby; p.center_b_z = cbz;
        p.radius_b = rb[30:0];
        return p;
    endfunction

    // Mostly pairs near each other so hits are common; some full range noise
    function automatic spcf_in_t random_pair();
        spcf_in_t p;
        logic [255:0] raw;
        int span;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        p = raw[$bits(spcf_in_t)-1:0];
        if ($urandom_range(0, 9) < 8)
        begin
            span = 1 << $urandom_range(4, 28);
            p.center_b_x = p.center_a_x + $signed($urandom_range(0, 2*span)) - span;
            p.center_b_y = p.center_a_y + $signed($urandom_range(0, 2*span)) - span;
            p.center_b_z = p.center_a_z + $signed($urandom_range(0, 2*span)) - span;
            p.radius_a = 31'($urandom_range(0, 2*span));
            p.radius_b = 31'($urandom_range(0, 2*span));
            if ($urandom_range(0, 19) == 0)
            begin
                p.center_b_x = p.center_a_x;
                p.center_b_y = p.center_a_y;
                p.center_b_z = p.center_a_z;
            end
        end
        return p;
    endfunction

    // Sender: bursts with gaps; payload holds until accepted
    task automatic send_pair(input spcf_in_t p);
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_data <= p;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        force_queue = {force_queue, predict_force(p, gain_now)};
        @(negedge clk);
    endtask

    task automatic write_gain(input logic [31:0] g);
        in_valid <= 1'b0;
        while (force_queue.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
        cfg_data <= g;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        gain_now = g;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver stall pattern: long open stretches, then choppy phases
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if ((cycles / 800) % 3 == 0)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        spcf_out_t want;
        cycles <= cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (out_data.hit)
                hits_seen++;
            if (force_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", out_data);
            end
            else
            begin
                want = force_queue.pop_front();
                if (want.hit !== out_data.hit || want.force_x !== out_data.force_x
                    || want.force_y !== out_data.force_y
                    || want.force_z !== out_data.force_z)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want %p got %p", want, out_data);
                end
            end
        end
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    pair_row_t   rows[N_ROWS];
    logic [31:0] gains[4];
    spcf_out_t   miss;

    initial
    begin
        miss = '0;
        gain_now = 32'h0000_8000;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // coincident centres give a hit with zero force
        rows[0] = '{make_pair(5, 5, 5, 100, 5, 5, 5, 1), 1'b1, spcf_out_t'({1'b1, 96'b0})};
        // zero radii never hit
        rows[1] = '{make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, miss};
        // far apart: miss
        rows[2] = '{make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0,
                              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0),
                    1'b1, miss};
        rows[3] = '{make_pair(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                              32'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                              32'sh7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, miss};
        // touching exactly: distance equals radius sum, no hit
        rows[4] = '{make_pair(0, 0, 0, 32'h10000, 32'h20000, 0, 0, 32'h10000), 1'b1, miss};
        rows[5] = '{make_pair(0, 0, 0, 32'h20000, 32'h10000, 0, 0, 32'h10000), 1'b0, miss};
        rows[6] = '{make_pair(0, 0, 0, 32'h20000, 0, -32'sh10000, 0, 32'h10000), 1'b0, miss};
        rows[7] = '{make_pair(0, 0, 0, 32'h20000, 0, 0, 32'h10000, 32'h10000), 1'b0, miss};
        rows[8] = '{make_pair(100, -100, 7, 32'h7FFF_FFFF, -3, 9, -300, 32'h7FFF_FFFF),
                    1'b0, miss};
        rows[9] = '{make_pair(1, 0, 0, 1, 0, 0, 0, 1), 1'b0, miss};

        gains = '{32'h0000_8000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000};
        foreach (gains[g])
        begin
            if (g != 0)
                write_gain(gains[g]);
            foreach (rows[i])
            begin
                if (rows[i].has_want && rows[i].want !== predict_force(rows[i].pair, gain_now))
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d disagrees with predictor", i);
                end
                send_pair(rows[i].pair);
            end
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 250 == 249)
                write_gain($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h40000));
            send_pair(random_pair());
        end
        in_valid <= 1'b0;

        while (force_queue.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        $display("%0d sphere pairs checked, %0d overlapping, over several gain settings",
                 results_seen, hits_seen);
        if (mismatches == 0 && force_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
